/* hw/rtl/rfm_pkg.sv */
// ----------------------------------------------------------------------------
// rfm_pkg: shared types and constants of the message framer
// Byte classes handed from the front classifier to the back parser, result
// event codes and message type codes.
// ----------------------------------------------------------------------------
package rfm_pkg;

  // Largest bulk or argument length that the result can carry.
  localparam logic [29:0] LEN_MAX = 30'h3FFF_FFFF;

  // Reset value of the bulk length limit.
  localparam logic [29:0] MAX_BULK_RESET = 30'd536870912;

  // Largest accepted multi-bulk count.
  localparam logic [31:0] COUNT_MAX = 32'h7FFF_FFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_REPLY_MODE = 2'd0;
  localparam logic [1:0] CFG_MAX_BULK   = 2'd1;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_ARG   = 2'd0,
    EV_DONE  = 2'd1,
    EV_ERROR = 2'd2
  } event_t;

  // Message type codes.
  localparam logic [2:0] MT_REQ_MULTI = 3'd0;
  localparam logic [2:0] MT_INLINE    = 3'd1;
  localparam logic [2:0] MT_REP_MULTI = 3'd2;
  localparam logic [2:0] MT_STATUS    = 3'd3;
  localparam logic [2:0] MT_ERRMSG    = 3'd4;
  localparam logic [2:0] MT_NUMBER    = 3'd5;
  localparam logic [2:0] MT_BULK      = 3'd6;

  // One classified stream byte.
  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic       is_name;   // a-z, '|' or '_'
    logic       is_blank;  // space or tab
    logic       is_cr;
    logic       is_lf;
    logic       is_at;
    logic       is_star;
    logic       is_plus;
    logic       is_minus;
    logic       is_colon;
    logic       is_dollar;
  } byte_item_t;

endpackage

/* hw/rtl/rfm_front.sv */
// ----------------------------------------------------------------------------
// rfm_front: byte classifier and request queue
// Accepts stream bytes, tags each with its character class and holds them
// in a four-entry queue for the parser.
// ----------------------------------------------------------------------------
module rfm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  output logic                q_valid,
  output rfm_pkg::byte_item_t q_item,
  input  logic                q_pop
);
  import rfm_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  byte_item_t   mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  byte_item_t   cls;
  logic         push;

  // Character classification of the incoming byte.
  always_comb begin
    cls           = '0;
    cls.data      = in_data_byte;
    cls.is_digit  = (in_data_byte >= 8'h30) && (in_data_byte <= 8'h39);
    cls.is_name   = ((in_data_byte >= 8'h61) && (in_data_byte <= 8'h7A)) ||
                    (in_data_byte == 8'h7C) || (in_data_byte == 8'h5F);
    cls.is_blank  = (in_data_byte == 8'h20) || (in_data_byte == 8'h09);
    cls.is_cr     = (in_data_byte == 8'h0D);
    cls.is_lf     = (in_data_byte == 8'h0A);
    cls.is_at     = (in_data_byte == 8'h40);
    cls.is_star   = (in_data_byte == 8'h2A);
    cls.is_plus   = (in_data_byte == 8'h2B);
    cls.is_minus  = (in_data_byte == 8'h2D);
    cls.is_colon  = (in_data_byte == 8'h3A);
    cls.is_dollar = (in_data_byte == 8'h24);
  end

  // Queue control.
  assign in_stall = (count_r == (AW+1)'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(push) - (AW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

/* hw/rtl/rfm_back.sv */
// ----------------------------------------------------------------------------
// rfm_back: protocol parser and result register
// Walks the message grammar one queued byte per cycle unless stalled, and
// places argument, completion and error events into an output register.
// ----------------------------------------------------------------------------
module rfm_back #(
  parameter int MAX_DIGITS  = 10,
  parameter int OFFSET_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                reply_mode,
  input  logic [29:0]         max_bulk_len,
  input  logic                q_valid,
  input  rfm_pkg::byte_item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_event_res,
  output logic [2:0]          out_msg_type,
  output logic [31:0]         out_arg_offset,
  output logic [29:0]         out_arg_length,
  output logic                out_arg_nil,
  output logic                out_msg_nil,
  output logic [63:0]         out_serial_number,
  output logic [31:0]         out_msg_length
);
  import rfm_pkg::*;

  localparam int DW = $clog2(MAX_DIGITS + 1);
  localparam int OB = OFFSET_BITS;

  typedef enum logic [3:0] {
    PH_START, PH_SESS, PH_BODY, PH_COUNT, PH_LEN, PH_DOLLAR, PH_CONTENT,
    PH_CR, PH_LF, PH_IN_SPACE, PH_IN_CHAR, PH_LINE
  } phase_t;

  typedef enum logic [1:0] {
    AN_DONE, AN_DOLLAR, AN_CONTENT, AN_SESS
  } after_t;

  phase_t        phase_r, phase_nxt;
  after_t        anl_r, anl_nxt;
  logic [DW-1:0] dcnt_r, dcnt_nxt;
  logic [31:0]   nval_r, nval_nxt;
  logic [1:0]    nflags_r, nflags_nxt;
  logic [31:0]   args_r, args_nxt;
  logic [29:0]   cleft_r, cleft_nxt;
  logic [OB-1:0] off_r, off_nxt;
  logic [OB-1:0] tok_r, tok_nxt;
  logic [2:0]    ctype_r, ctype_nxt;
  logic [63:0]   serial_r, serial_nxt;
  logic          nil_r, nil_nxt;

  logic          err, done, has_res, do_body, body_line;
  event_t        r_ev;
  logic [OB-1:0] r_aoff, off1, tok_diff;
  logic [63:0]   r_alen, a64, m64;
  logic          r_anil;
  logic [2:0]    r_type;
  logic          r_mnil;
  logic [63:0]   r_serial;
  logic [35:0]   nprod;
  logic [63:0]   sprod;
  logic [31:0]   nsat;
  logic          out_free;

  logic          out_valid_r;
  logic [1:0]    ev_r;
  logic [2:0]    type_r;
  logic [31:0]   aoff_r;
  logic [29:0]   alen_r;
  logic          anil_r;
  logic          mnil_r;
  logic [63:0]   ser_r;
  logic [31:0]   mlen_r;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_valid && out_free;

  // Decimal accumulators: times ten by shift and add.
  always_comb begin
    nprod = {1'b0, nval_r, 3'b0} + {3'b0, nval_r, 1'b0} + {32'b0, q_item.data[3:0]};
    nsat  = (|nprod[35:32]) ? 32'hFFFF_FFFF : nprod[31:0];
    sprod = {serial_r[60:0], 3'b0} + {serial_r[62:0], 1'b0} +
            {60'b0, q_item.data[3:0]};
    off1     = off_r + 1'b1;
    tok_diff = off_r - tok_r;
  end

  // Parser next state.
  always_comb begin
    phase_nxt  = phase_r;
    anl_nxt    = anl_r;
    dcnt_nxt   = dcnt_r;
    nval_nxt   = nval_r;
    nflags_nxt = nflags_r;
    args_nxt   = args_r;
    cleft_nxt  = cleft_r;
    off_nxt    = off_r;
    tok_nxt    = tok_r;
    ctype_nxt  = ctype_r;
    serial_nxt = serial_r;
    nil_nxt    = nil_r;
    err        = 1'b0;
    done       = 1'b0;
    has_res    = 1'b0;
    do_body    = 1'b0;
    body_line  = 1'b0;
    r_ev       = EV_ARG;
    r_aoff     = '0;
    r_alen     = '0;
    r_anil     = 1'b0;

    case (phase_r)
      PH_START: begin
        if (q_item.is_at) begin
          nflags_nxt = '0;
          phase_nxt  = PH_SESS;
        end else begin
          do_body = 1'b1;
        end
      end
      PH_SESS: begin
        if (q_item.is_digit) begin
          if (reply_mode) begin
            serial_nxt = sprod;
          end
          nflags_nxt = 2'd1;
        end else if (q_item.is_name) begin
          nflags_nxt = 2'd1;
        end else if (q_item.is_cr && (nflags_r != '0)) begin
          anl_nxt   = AN_SESS;
          phase_nxt = PH_LF;
        end else begin
          err = 1'b1;
        end
      end
      PH_BODY: do_body = 1'b1;
      PH_COUNT, PH_LEN: begin
        if (q_item.is_cr) begin
          if ((dcnt_r == '0) || (nflags_r[0] && (nval_r != 32'd1))) begin
            err = 1'b1;
          end else if (phase_r == PH_COUNT) begin
            if (nflags_r[0]) begin
              nil_nxt  = 1'b1;
              args_nxt = 32'd1;
            end else if (nval_r > COUNT_MAX) begin
              err = 1'b1;
            end else begin
              args_nxt = (nval_r != '0) ? nval_r + 32'd1 : 32'd1;
            end
            anl_nxt   = AN_DOLLAR;
            phase_nxt = PH_LF;
          end else if (nflags_r[0]) begin
            has_res   = 1'b1;
            r_anil    = 1'b1;
            anl_nxt   = (ctype_r == MT_BULK) ? AN_DONE : AN_DOLLAR;
            phase_nxt = PH_LF;
          end else if (nval_r > {2'b0, max_bulk_len}) begin
            err = 1'b1;
          end else begin
            anl_nxt   = AN_CONTENT;
            phase_nxt = PH_LF;
          end
        end else if (q_item.is_digit || q_item.is_minus) begin
          if (dcnt_r >= DW'(MAX_DIGITS)) begin
            err = 1'b1;
          end else begin
            if (q_item.is_minus) begin
              if (dcnt_r == '0) begin
                nflags_nxt[0] = 1'b1;
              end else begin
                nflags_nxt[1] = 1'b1;
              end
            end else if (!nflags_r[1]) begin
              nval_nxt = nsat;
            end
            dcnt_nxt = dcnt_r + 1'b1;
          end
        end else begin
          err = 1'b1;
        end
      end
      PH_DOLLAR: begin
        if (!q_item.is_dollar) begin
          err = 1'b1;
        end else begin
          dcnt_nxt   = '0;
          nval_nxt   = '0;
          nflags_nxt = '0;
          phase_nxt  = PH_LEN;
        end
      end
      PH_CONTENT: begin
        cleft_nxt = cleft_r - 1'b1;
        if (cleft_nxt == '0) begin
          has_res   = 1'b1;
          r_aoff    = tok_r;
          r_alen    = {32'b0, nval_r};
          phase_nxt = PH_CR;
        end
      end
      PH_CR: begin
        if (!q_item.is_cr) begin
          err = 1'b1;
        end else begin
          anl_nxt   = (ctype_r == MT_BULK) ? AN_DONE : AN_DOLLAR;
          phase_nxt = PH_LF;
        end
      end
      PH_LF: begin
        if (!q_item.is_lf) begin
          err = 1'b1;
        end else begin
          case (anl_r)
            AN_DOLLAR: begin
              args_nxt = (args_r != '0) ? args_r - 32'd1 : 32'd0;
              if (args_nxt == '0) begin
                done = 1'b1;
              end else begin
                phase_nxt = PH_DOLLAR;
              end
            end
            AN_CONTENT: begin
              cleft_nxt = nval_r[29:0];
              tok_nxt   = off1;
              if (nval_r[29:0] == '0) begin
                has_res   = 1'b1;
                r_aoff    = off1;
                phase_nxt = PH_CR;
              end else begin
                phase_nxt = PH_CONTENT;
              end
            end
            AN_SESS: phase_nxt = PH_BODY;
            default: done = 1'b1;
          endcase
        end
      end
      PH_IN_SPACE: begin
        if (q_item.is_cr) begin
          anl_nxt   = AN_DONE;
          phase_nxt = PH_LF;
        end else if (!q_item.is_blank) begin
          tok_nxt   = off_r;
          phase_nxt = PH_IN_CHAR;
        end
      end
      PH_IN_CHAR: begin
        if (q_item.is_blank || q_item.is_cr) begin
          has_res = 1'b1;
          r_aoff  = tok_r;
          r_alen  = 64'(tok_diff);
          if (q_item.is_cr) begin
            anl_nxt   = AN_DONE;
            phase_nxt = PH_LF;
          end else begin
            phase_nxt = PH_IN_SPACE;
          end
        end
      end
      PH_LINE: begin
        if (q_item.is_cr) begin
          has_res   = 1'b1;
          r_aoff    = tok_r;
          r_alen    = 64'(tok_diff);
          anl_nxt   = AN_DONE;
          phase_nxt = PH_LF;
        end
      end
      default: err = 1'b1;
    endcase

    // First byte of a message body: request or reply type.
    if (do_body) begin
      if (!reply_mode) begin
        if (q_item.is_star) begin
          ctype_nxt  = MT_REQ_MULTI;
          dcnt_nxt   = '0;
          nval_nxt   = '0;
          nflags_nxt = '0;
          phase_nxt  = PH_COUNT;
        end else begin
          ctype_nxt = MT_INLINE;
          if (q_item.is_blank) begin
            phase_nxt = PH_IN_SPACE;
          end else if (q_item.is_cr) begin
            anl_nxt   = AN_DONE;
            phase_nxt = PH_LF;
          end else begin
            tok_nxt   = off_r;
            phase_nxt = PH_IN_CHAR;
          end
        end
      end else if (q_item.is_star || q_item.is_dollar) begin
        ctype_nxt  = q_item.is_star ? MT_REP_MULTI : MT_BULK;
        dcnt_nxt   = '0;
        nval_nxt   = '0;
        nflags_nxt = '0;
        phase_nxt  = q_item.is_star ? PH_COUNT : PH_LEN;
      end else if (q_item.is_plus) begin
        ctype_nxt = MT_STATUS;
        body_line = 1'b1;
      end else if (q_item.is_minus) begin
        ctype_nxt = MT_ERRMSG;
        body_line = 1'b1;
      end else if (q_item.is_colon) begin
        ctype_nxt = MT_NUMBER;
        body_line = 1'b1;
      end else begin
        err = 1'b1;
      end
      if (body_line) begin
        tok_nxt   = off1;
        phase_nxt = PH_LINE;
      end
    end

    // Result fields, taken before a message restart clears the state.
    r_type   = ctype_nxt;
    r_mnil   = err ? 1'b0 : nil_nxt;
    r_serial = (!err && reply_mode) ? serial_nxt : 64'd0;
    if (err) begin
      has_res = 1'b1;
      r_ev    = EV_ERROR;
      r_aoff  = '0;
      r_alen  = '0;
      r_anil  = 1'b0;
    end else if (done) begin
      has_res = 1'b1;
      r_ev    = EV_DONE;
    end

    // Restart at the next byte after a completion or an error.
    if (err || done) begin
      phase_nxt  = PH_START;
      anl_nxt    = AN_DONE;
      dcnt_nxt   = '0;
      nval_nxt   = '0;
      nflags_nxt = '0;
      args_nxt   = '0;
      cleft_nxt  = '0;
      off_nxt    = '0;
      tok_nxt    = '0;
      ctype_nxt  = MT_REQ_MULTI;
      serial_nxt = '0;
      nil_nxt    = 1'b0;
    end else begin
      off_nxt = off1;
    end

    a64 = 64'(r_aoff);
    m64 = 64'(off1);
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      anl_r    <= AN_DONE;
      dcnt_r   <= '0;
      nval_r   <= '0;
      nflags_r <= '0;
      args_r   <= '0;
      cleft_r  <= '0;
      off_r    <= '0;
      tok_r    <= '0;
      ctype_r  <= MT_REQ_MULTI;
      serial_r <= '0;
      nil_r    <= 1'b0;
    end else if (q_pop) begin
      phase_r  <= phase_nxt;
      anl_r    <= anl_nxt;
      dcnt_r   <= dcnt_nxt;
      nval_r   <= nval_nxt;
      nflags_r <= nflags_nxt;
      args_r   <= args_nxt;
      cleft_r  <= cleft_nxt;
      off_r    <= off_nxt;
      tok_r    <= tok_nxt;
      ctype_r  <= ctype_nxt;
      serial_r <= serial_nxt;
      nil_r    <= nil_nxt;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= q_pop && has_res;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (q_pop && has_res) begin
      ev_r   <= r_ev;
      type_r <= r_type;
      aoff_r <= (r_ev == EV_ARG && !r_anil) ? a64[31:0] : 32'd0;
      alen_r <= (r_alen > {34'b0, LEN_MAX}) ? LEN_MAX : r_alen[29:0];
      anil_r <= r_anil;
      mnil_r <= r_mnil;
      ser_r  <= r_serial;
      mlen_r <= (r_ev == EV_DONE) ? m64[31:0] : 32'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = ev_r;
  assign out_msg_type      = type_r;
  assign out_arg_offset    = aoff_r;
  assign out_arg_length    = alen_r;
  assign out_arg_nil       = anil_r;
  assign out_msg_nil       = mnil_r;
  assign out_serial_number = ser_r;
  assign out_msg_length    = mlen_r;

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r == EV_ERROR) |-> (ser_r == '0 && !mnil_r && mlen_r == '0))
    else $error("error result carries message data");
  a_nil_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && anil_r) |-> (alen_r == '0 && aoff_r == '0))
    else $error("nil argument with nonzero length");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (err || done)) |=> (phase_r == PH_START && off_r == '0))
    else $error("parser did not restart after a message end");

endmodule

/* hw/rtl/resp_message_framer_unit.sv */
// ----------------------------------------------------------------------------
// resp_message_framer_unit: byte-serial framer for a key-value-store protocol
// Classifies stream bytes, parses requests or replies, and reports arguments,
// message completions and protocol errors.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the in_ channel, one request per byte. Each byte yields at
// most one result on the out_ channel: an argument, a message completion or
// an error, with the message type, lengths and the session serial number.
// The cfg_ channel writes reply_mode (index 0) and max_bulk_len (index 1);
// cfg_ready is always high. Write it only while no byte is in flight.
// A byte passes a four-entry queue and the parser; its result waits in the
// result register until taken. The parser takes one byte per cycle while the
// receiver does not stall, so the sustained rate is then one byte per cycle.
// When the receiver stalls a valid result, the result register holds and the
// parser stops; the queue absorbs up to four more bytes before in_stall rises.
// Reset clears the queue, the result valid flag and the parser, and sets
// reply_mode to 0 and max_bulk_len to 2^29.
// ----------------------------------------------------------------------------
module resp_message_framer_unit #(
  parameter int MAX_DIGITS  = 10,
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [2:0]  out_msg_type,
  output logic [31:0] out_arg_offset,
  output logic [29:0] out_arg_length,
  output logic        out_arg_nil,
  output logic        out_msg_nil,
  output logic [63:0] out_serial_number,
  output logic [31:0] out_msg_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_data
);
  import rfm_pkg::*;

  logic        reply_mode_r;
  logic [29:0] max_bulk_r;
  logic        q_valid;
  logic        q_pop;
  byte_item_t  q_item;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_mode_r <= 1'b0;
      max_bulk_r   <= MAX_BULK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_REPLY_MODE) begin
        reply_mode_r <= cfg_data[0];
      end else if (cfg_index == CFG_MAX_BULK) begin
        max_bulk_r <= cfg_data;
      end
    end
  end

  // Classifier and queue.
  rfm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // Parser and result register.
  rfm_back #(
    .MAX_DIGITS  (MAX_DIGITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .reply_mode        (reply_mode_r),
    .max_bulk_len      (max_bulk_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_msg_type      (out_msg_type),
    .out_arg_offset    (out_arg_offset),
    .out_arg_length    (out_arg_length),
    .out_arg_nil       (out_arg_nil),
    .out_msg_nil       (out_msg_nil),
    .out_serial_number (out_serial_number),
    .out_msg_length    (out_msg_length)
  );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for resp_message_framer_unit
// Streams request and reply messages, with broken frames and noise mixed in,
// through the framer. A predictor follows the parse byte by byte and every
// result is compared against its oldest expectation. Both sides idle at
// random, and the configuration changes between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module testbench;
  import rfm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int OFFSET_BITS = 32;
  localparam int MAX_DIGITS = 10;

  typedef enum logic [3:0] {
    PH_START, PH_SESS, PH_BODY, PH_COUNT, PH_LEN, PH_DOLLAR, PH_CONTENT,
    PH_CR, PH_LF, PH_IN_SPACE, PH_IN_CHAR, PH_LINE
  } parse_phase_t;

  typedef enum logic [1:0] {
    NL_DONE, NL_DOLLAR, NL_CONTENT, NL_SESS
  } newline_action_t;

  typedef struct packed {
    event_t      ev;
    logic [2:0]  mtype;
    logic [31:0] aoff;
    logic [29:0] alen;
    logic        anil;
    logic        mnil;
    logic [63:0] serial;
    logic [31:0] mlen;
  } frame_event_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_event_res;
  logic [2:0]  out_msg_type;
  logic [31:0] out_arg_offset;
  logic [29:0] out_arg_length;
  logic        out_arg_nil;
  logic        out_msg_nil;
  logic [63:0] out_serial_number;
  logic [31:0] out_msg_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [29:0] cfg_data;

  // Stream bytes waiting for the driver and events the framer still owes.
  logic [7:0]   stream_bytes[$];
  frame_event_t owed_events[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           send_gap = 0;
  int           stall_left = 0;
  bit           steady = 0;

  // Predictor copy of the configuration.
  logic        reply_mode = 1'b0;
  logic [29:0] max_bulk = MAX_BULK_RESET;

  // Predictor copy of the parser state.
  parse_phase_t    phase = PH_START;
  newline_action_t nl_action = NL_DONE;
  int              digit_count = 0;
  logic [31:0]     number_value = '0;
  logic [1:0]      number_flags = '0;
  logic [31:0]     args_left = '0;
  logic [29:0]     content_left = '0;
  logic [31:0]     byte_offset = '0;
  logic [31:0]     token_begin = '0;
  logic [2:0]      cur_type = '0;
  logic [63:0]     serial_acc = '0;
  logic            nil_message = 1'b0;

  resp_message_framer_unit #(
    .MAX_DIGITS(MAX_DIGITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_res(out_event_res), .out_msg_type(out_msg_type),
    .out_arg_offset(out_arg_offset), .out_arg_length(out_arg_length),
    .out_arg_nil(out_arg_nil), .out_msg_nil(out_msg_nil),
    .out_serial_number(out_serial_number), .out_msg_length(out_msg_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clears the parse state so that the next byte opens a new message.
  function automatic void restart_message();
    phase = PH_START;
    nl_action = NL_DONE;
    digit_count = 0;
    number_value = '0;
    number_flags = '0;
    args_left = '0;
    content_left = '0;
    byte_offset = '0;
    token_begin = '0;
    cur_type = '0;
    serial_acc = '0;
    nil_message = 1'b0;
  endfunction

  function automatic frame_event_t make_event(event_t ev, logic [31:0] aoff,
                                              logic [31:0] alen, logic anil,
                                              logic [31:0] mlen);
    frame_event_t e;
    e.ev = ev;
    e.mtype = cur_type;
    e.aoff = aoff;
    e.alen = (alen > {2'b00, LEN_MAX}) ? LEN_MAX : alen[29:0];
    e.anil = anil;
    e.mnil = (ev == EV_ERROR) ? 1'b0 : nil_message;
    e.serial = (ev != EV_ERROR && reply_mode) ? serial_acc : 64'd0;
    e.mlen = mlen;
    return e;
  endfunction

  function automatic void clear_number();
    digit_count = 0;
    number_value = '0;
    number_flags = '0;
  endfunction

  // Adds a digit or a minus sign; returns 0 when the number is too long.
  function automatic bit add_number_char(logic [7:0] c);
    logic [35:0] grown;
    if (digit_count >= MAX_DIGITS) return 1'b0;
    if (c == "-") begin
      if (digit_count == 0) number_flags[0] = 1'b1;
      else number_flags[1] = 1'b1;
    end else if (!number_flags[1]) begin
      grown = number_value * 36'd10 + (c - 8'd48);
      number_value = (grown > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
    end
    digit_count++;
    return 1'b1;
  endfunction

  // Handles the type byte of a message body; returns 0 on an unknown reply type.
  function automatic bit open_body(logic [7:0] c, logic [31:0] off);
    if (!reply_mode) begin
      if (c == "*") begin
        cur_type = MT_REQ_MULTI;
        clear_number();
        phase = PH_COUNT;
      end else begin
        cur_type = MT_INLINE;
        if (c == " " || c == 8'h09) begin
          phase = PH_IN_SPACE;
        end else if (c == 8'h0D) begin
          nl_action = NL_DONE;
          phase = PH_LF;
        end else begin
          token_begin = off;
          phase = PH_IN_CHAR;
        end
      end
      return 1'b1;
    end
    case (c)
      "*": begin
        cur_type = MT_REP_MULTI;
        clear_number();
        phase = PH_COUNT;
        return 1'b1;
      end
      "$": begin
        cur_type = MT_BULK;
        clear_number();
        phase = PH_LEN;
        return 1'b1;
      end
      "+": cur_type = MT_STATUS;
      "-": cur_type = MT_ERRMSG;
      ":": cur_type = MT_NUMBER;
      default: return 1'b0;
    endcase
    token_begin = off + 1;
    phase = PH_LINE;
    return 1'b1;
  endfunction

  // Advances the parse by one accepted byte and records any event it causes.
  function automatic void frame_byte(logic [7:0] c);
    logic [31:0]  off;
    bit           fault;
    bit           done;
    bit           have;
    bit           neg;
    frame_event_t e;
    off = byte_offset;
    fault = 0;
    done = 0;
    have = 0;
    case (phase)
      PH_START: begin
        if (c == "@") begin
          number_flags = '0;
          phase = PH_SESS;
        end else begin
          fault = !open_body(c, off);
        end
      end
      PH_SESS: begin
        if (c >= "0" && c <= "9") begin
          if (reply_mode) serial_acc = serial_acc * 64'd10 + (c - 8'd48);
          number_flags = 2'd1;
        end else if ((c >= "a" && c <= "z") || c == "|" || c == "_") begin
          number_flags = 2'd1;
        end else if (c == 8'h0D && number_flags != 0) begin
          nl_action = NL_SESS;
          phase = PH_LF;
        end else begin
          fault = 1;
        end
      end
      PH_BODY: fault = !open_body(c, off);
      PH_COUNT, PH_LEN: begin
        if (c == 8'h0D) begin
          neg = number_flags[0];
          if (digit_count == 0 || (neg && number_value != 32'd1)) begin
            fault = 1;
          end else if (phase == PH_COUNT) begin
            if (neg) begin
              nil_message = 1'b1;
              args_left = 32'd1;
            end else if (number_value > COUNT_MAX) begin
              fault = 1;
            end else begin
              args_left = (number_value != 0) ? number_value + 1 : 32'd1;
            end
            nl_action = NL_DOLLAR;
            phase = PH_LF;
          end else if (neg) begin
            e = make_event(EV_ARG, '0, '0, 1'b1, '0);
            have = 1;
            nl_action = (cur_type == MT_BULK) ? NL_DONE : NL_DOLLAR;
            phase = PH_LF;
          end else if (number_value > {2'b00, max_bulk}) begin
            fault = 1;
          end else begin
            nl_action = NL_CONTENT;
            phase = PH_LF;
          end
        end else if ((c >= "0" && c <= "9") || c == "-") begin
          fault = !add_number_char(c);
        end else begin
          fault = 1;
        end
      end
      PH_DOLLAR: begin
        if (c != "$") begin
          fault = 1;
        end else begin
          clear_number();
          phase = PH_LEN;
        end
      end
      PH_CONTENT: begin
        content_left = content_left - 1;
        if (content_left == 0) begin
          e = make_event(EV_ARG, token_begin, number_value, 1'b0, '0);
          have = 1;
          phase = PH_CR;
        end
      end
      PH_CR: begin
        if (c != 8'h0D) begin
          fault = 1;
        end else begin
          nl_action = (cur_type == MT_BULK) ? NL_DONE : NL_DOLLAR;
          phase = PH_LF;
        end
      end
      PH_LF: begin
        if (c != 8'h0A) begin
          fault = 1;
        end else if (nl_action == NL_DOLLAR) begin
          if (args_left != 0) args_left--;
          if (args_left == 0) done = 1;
          else phase = PH_DOLLAR;
        end else if (nl_action == NL_CONTENT) begin
          content_left = number_value[29:0];
          token_begin = off + 1;
          if (content_left == 0) begin
            e = make_event(EV_ARG, token_begin, '0, 1'b0, '0);
            have = 1;
            phase = PH_CR;
          end else begin
            phase = PH_CONTENT;
          end
        end else if (nl_action == NL_SESS) begin
          phase = PH_BODY;
        end else begin
          done = 1;
        end
      end
      PH_IN_SPACE: begin
        if (c == 8'h0D) begin
          nl_action = NL_DONE;
          phase = PH_LF;
        end else if (c != " " && c != 8'h09) begin
          token_begin = off;
          phase = PH_IN_CHAR;
        end
      end
      PH_IN_CHAR: begin
        if (c == " " || c == 8'h09 || c == 8'h0D) begin
          e = make_event(EV_ARG, token_begin, off - token_begin, 1'b0, '0);
          have = 1;
          if (c == 8'h0D) begin
            nl_action = NL_DONE;
            phase = PH_LF;
          end else begin
            phase = PH_IN_SPACE;
          end
        end
      end
      PH_LINE: begin
        if (c == 8'h0D) begin
          e = make_event(EV_ARG, token_begin, off - token_begin, 1'b0, '0);
          have = 1;
          nl_action = NL_DONE;
          phase = PH_LF;
        end
      end
      default: fault = 1;
    endcase

    if (fault) begin
      owed_events.insert(owed_events.size(), make_event(EV_ERROR, '0, '0, 1'b0, '0));
      restart_message();
    end else if (done) begin
      owed_events.insert(owed_events.size(), make_event(EV_DONE, '0, '0, 1'b0, off + 1));
      restart_message();
    end else begin
      if (have) owed_events.insert(owed_events.size(), e);
      byte_offset = off + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  // Gap length: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void put_text(ref logic [7:0] frame[$], input string s);
    for (int i = 0; i < s.len(); i++) frame.insert(frame.size(), s[i]);
  endfunction

  function automatic logic [7:0] any_byte_except_crlf_blank();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == 8'h0D || b == " " || b == 8'h09);
    return b;
  endfunction

  // A count or length string; now and then a malformed one.
  function automatic string number_text(int n);
    string odd[9] = '{"", "-", "-2", "--1", "1-9", "12345678901", "4294967296",
                      "2147483648", "-0"};
    if ($urandom_range(0, 99) < 4) return odd[$urandom_range(0, 8)];
    return $sformatf("%0d", n);
  endfunction

  // One bulk string: length line then content, or a nil bulk, or now and then an over-limit length line alone.
  function automatic void put_bulk(ref logic [7:0] frame[$]);
    int unsigned len;
    int unsigned cap;
    cap = (max_bulk < 12) ? max_bulk : 12;
    if ($urandom_range(0, 9) == 0) begin
      put_text(frame, "$-1\r\n");
      return;
    end
    if (max_bulk != LEN_MAX && $urandom_range(0, 19) == 0) begin
      put_text(frame, $sformatf("$%0d\r\n", max_bulk + 1 + $urandom_range(0, 3)));
      return;
    end
    len = $urandom_range(0, cap);
    put_text(frame, {"$", number_text(len), "\r\n"});
    for (int i = 0; i < len; i++) frame.insert(frame.size(), 8'($urandom_range(0, 255)));
    put_text(frame, "\r\n");
  endfunction

  // One message, well formed mostly, sometimes with one byte broken; now and then random noise instead.
  function automatic void queue_message();
    logic [7:0] frame[$];
    string      name_chars = "0123456789azmq|_";
    int         kind;
    int         n;
    bit         as_reply;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) frame.insert(frame.size(), 8'($urandom_range(0, 255)));
      foreach (frame[i]) stream_bytes.insert(stream_bytes.size(), frame[i]);
      return;
    end
    if ($urandom_range(0, 4) == 0) begin
      frame.insert(frame.size(), "@");
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++)
        frame.insert(frame.size(), name_chars[$urandom_range(0, 15)]);
      put_text(frame, "\r\n");
    end
    as_reply = ($urandom_range(0, 9) == 0) ? !reply_mode : reply_mode;
    kind = $urandom_range(0, 4);
    if (!as_reply) begin
      if (kind < 3) begin
        n = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, 4);
        put_text(frame, {"*", number_text(n), "\r\n"});
        for (int i = 0; i < n; i++) put_bulk(frame);
      end else begin
        n = $urandom_range(0, 3);
        for (int w = 0; w < n; w++) begin
          if ($urandom_range(0, 1))
            frame.insert(frame.size(), ($urandom_range(0, 1)) ? 8'h20 : 8'h09);
          for (int i = $urandom_range(1, 6); i > 0; i--)
            frame.insert(frame.size(), any_byte_except_crlf_blank());
          frame.insert(frame.size(), " ");
        end
        put_text(frame, "\r\n");
      end
    end else begin
      case (kind)
        0: begin
          n = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, 4);
          put_text(frame, {"*", number_text(n), "\r\n"});
          for (int i = 0; i < n; i++) put_bulk(frame);
        end
        1: put_bulk(frame);
        default: begin
          frame.insert(frame.size(), (kind == 2) ? "+" : (kind == 3) ? "-" : ":");
          for (int i = $urandom_range(0, 8); i > 0; i--)
            frame.insert(frame.size(), any_byte_except_crlf_blank());
          put_text(frame, "\r\n");
        end
      endcase
    end
    if ($urandom_range(0, 9) == 0)
      frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
    foreach (frame[i]) stream_bytes.insert(stream_bytes.size(), frame[i]);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) stream_bytes.insert(stream_bytes.size(), s[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic       next_valid;
    logic [7:0] next_byte;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("resp_message_framer_unit verification failed");
      $finish;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_byte = in_data_byte;
      if (in_valid && !in_stall) begin
        frame_byte(in_data_byte);
        send_gap = pick_gap();
        next_valid = 1'b0;
      end
      if (!next_valid || !in_valid || !in_stall) begin
        if (!(in_valid && in_stall)) begin
          if (send_gap > 0) begin
            send_gap--;
            next_valid = 1'b0;
          end else if (stream_bytes.size() != 0) begin
            next_byte = stream_bytes.pop_front();
            next_valid = 1'b1;
          end else begin
            next_valid = 1'b0;
          end
        end
      end
      in_valid <= next_valid;
      in_data_byte <= next_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver stalls
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    frame_event_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_events.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual event %0d",
                   $time, out_event_res);
          fail_count++;
        end else begin
          want = owed_events.pop_front();
          check_field("event_res", want.ev, out_event_res);
          check_field("msg_type", want.mtype, out_msg_type);
          check_field("arg_offset", want.aoff, out_arg_offset);
          check_field("arg_length", want.alen, out_arg_length);
          check_field("arg_nil", want.anil, out_arg_nil);
          check_field("msg_nil", want.mnil, out_msg_nil);
          check_field("serial_number", want.serial, out_serial_number);
          check_field("msg_length", want.mlen, out_msg_length);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Phase control
  // ---------------------------------------------------------------------------

  // Waits until every byte is sent and every event has come, then lets the
  // pipeline drain of bytes that cause no event.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (stream_bytes.size() != 0 || in_valid || owed_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [29:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == CFG_REPLY_MODE) reply_mode = value[0];
    else if (index == CFG_MAX_BULK) max_bulk = value;
  endtask

  initial begin
    logic [29:0] bulk_limits[10];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: counts, nil and empty forms, inline words, prefixes,
    // malformed numbers and missing delimiters.
    queue_text("*2\r\n$3\r\nSET\r\n$0\r\n\r\n");
    queue_text("*-1\r\n");
    queue_text("*0\r\n");
    queue_text("*1\r\n$-1\r\n");
    queue_text("  GET\tkey \r\n");
    queue_text("\r\n");
    queue_text("@ab_|9\r\n*1\r\n$1\r\n\xff\r\n");
    queue_text("@\r\n");
    queue_text("@A");
    queue_text("*12345678901\r\n");
    queue_text("*4294967296\r\n");
    queue_text("*-2\r\n");
    queue_text("*\r\n");
    queue_text("*1-5\r\n$1\r\nz\r\n");
    queue_text("*1\r\nX");
    queue_text("*1\r\n$1\r\nab");
    queue_text("x@\r\n");
    wait_drained();

    // Directed replies, with a small bulk limit and a wrapping serial number.
    write_register(CFG_REPLY_MODE, 30'd1);
    write_register(CFG_MAX_BULK, 30'd5);
    queue_text("+OK\r\n");
    queue_text("-ERR x\r\n");
    queue_text(":-12\r\n");
    queue_text("$5\r\nhello\r\n");
    queue_text("$6\r\n");
    queue_text("$-1\r\n");
    queue_text("$0\r\n\r\n");
    queue_text("*2\r\n$1\r\na\r\n$-1\r\n");
    queue_text("*-1\r\n");
    queue_text("?x");
    queue_text("$1\r\nq\rX");
    queue_text("@99999999999999999999123\r\n+A\r\n");
    wait_drained();

    // Random phases over alternating modes and a spread of bulk limits.
    bulk_limits = '{MAX_BULK_RESET, LEN_MAX, 30'd0, 30'd0, LEN_MAX, 30'd3,
                    30'd1, 30'd7, 30'd0, 30'd0};
    bulk_limits[8] = 30'($urandom_range(0, 20));
    bulk_limits[9] = 30'($urandom);
    for (int p = 0; p < 10; p++) begin
      write_register(CFG_REPLY_MODE, 30'(p[0]));
      write_register(CFG_MAX_BULK, bulk_limits[p]);
      steady = (p % 3 == 2);
      while (stream_bytes.size() < 80) queue_message();
      wait_drained();
    end
    steady = 0;

    if (fail_count == 0) begin
      $display("resp_message_framer_unit verification clean");
    end else begin
      $display("resp_message_framer_unit verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rfm_pkg.sv
hw/rtl/rfm_front.sv
hw/rtl/rfm_back.sv
hw/rtl/resp_message_framer_unit.sv
tb/sv/testbench.sv
